// ----- rtl/core/ttq_pkg.sv -----
package ttq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int RUN_LIMIT       = 16;
    localparam int OCC_W           = 5;

    localparam logic REQ_ADD = 1'b0;
    localparam logic REQ_RUN = 1'b1;

    localparam logic [1:0] KIND_ADD_OK   = 2'd0;
    localparam logic [1:0] KIND_ADD_FULL = 2'd1;
    localparam logic [1:0] KIND_TASK_DUE = 2'd2;
    localparam logic [1:0] KIND_NONE_DUE = 2'd3;

    typedef struct packed {
        logic        req_type;
        logic [31:0] time_sec;
        logic [29:0] time_nsec;
        logic [15:0] task_tag;
    } ttq_req_t;

    typedef struct packed {
        logic [1:0]       result_kind;
        logic [15:0]      due_tag;
        logic             last_result;
        logic [OCC_W-1:0] occupancy;
    } ttq_rsp_t;

    typedef struct packed {
        logic [31:0] sec;
        logic [29:0] nsec;
        logic [15:0] tag;
    } ttq_entry_t;

    typedef struct packed {
        logic       load_req;
        logic       idx_init;
        logic       rd_add;
        logic       rd_run;
        logic       wr_shift;
        logic       wr_new;
        logic       due_inc;
        logic       emit;
        logic [1:0] emit_kind;
        logic       emit_last;
        logic       commit_add;
        logic       commit_run;
    } ttq_cmd_t;

    typedef struct packed {
        logic req_run;
        logic full;
        logic idx_zero;
        logic entry_later;
        logic due_stop;
        logic due_zero;
        logic out_free;
    } ttq_status_t;

endpackage

// ----- rtl/core/ttq_ram.sv -----
module ttq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/ttq_datapath.sv -----
module ttq_datapath #(
    parameter int QUEUE_DEPTH = ttq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  ttq_pkg::ttq_req_t   req_data,
    input  ttq_pkg::ttq_cmd_t   cmd,
    output ttq_pkg::ttq_status_t status,
    input  logic                rsp_stall,
    output logic                rsp_valid,
    output ttq_pkg::ttq_rsp_t   rsp_data
);

    import ttq_pkg::*;

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = CW + 1;
    localparam int EW = $bits(ttq_entry_t);
    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
    localparam logic [SW-1:0] DEPTH_S = SW'(QUEUE_DEPTH);

    ttq_req_t       req_reg;
    logic [CW-1:0]  count_reg;
    logic [CW-1:0]  count_next;
    logic [AW-1:0]  head_reg;
    logic [AW-1:0]  head_next;
    logic [CW-1:0]  idx_reg;
    logic [CW-1:0]  idx_next;
    logic [CW-1:0]  due_reg;
    logic [CW-1:0]  due_next;
    logic [15:0]    pend_tag_reg;
    logic           rsp_valid_reg;
    logic           rsp_valid_next;
    ttq_rsp_t       rsp_reg;
    ttq_rsp_t       rsp_new;

    logic           ram_we;
    logic           ram_re;
    logic [AW-1:0]  ram_waddr;
    logic [AW-1:0]  ram_raddr;
    logic [EW-1:0]  ram_wdata;
    logic [EW-1:0]  ram_rdata;
    ttq_entry_t     rd_entry;
    ttq_entry_t     new_entry;
    logic [CW-1:0]  rd_lidx;
    logic [CW-1:0]  occ_calc;
    logic [61:0]    rd_key;
    logic [61:0]    new_key;

    // Map a queue position onto a RAM address of the circular buffer.
    function automatic logic [AW-1:0] phys_addr(input logic [AW-1:0] base,
                                                input logic [CW-1:0] ofs);
        logic [SW-1:0] sum;
        sum = SW'(base) + SW'(ofs);
        if (sum >= DEPTH_S)
        begin
            sum = sum - DEPTH_S;
        end
        return sum[AW-1:0];
    endfunction

    always_comb
    begin
        new_entry.sec  = req_reg.time_sec;
        new_entry.nsec = req_reg.time_nsec;
        new_entry.tag  = req_reg.task_tag;
    end

    assign rd_entry = ram_rdata;
    assign rd_key   = {rd_entry.sec, rd_entry.nsec};
    assign new_key  = {req_reg.time_sec, req_reg.time_nsec};

    assign rd_lidx   = cmd.rd_run ? due_reg : (idx_reg - CW'(1));
    assign ram_re    = cmd.rd_add | cmd.rd_run;
    assign ram_raddr = phys_addr(head_reg, rd_lidx);
    assign ram_we    = cmd.wr_shift | cmd.wr_new;
    assign ram_waddr = phys_addr(head_reg, idx_reg);
    assign ram_wdata = cmd.wr_shift ? ram_rdata : EW'(new_entry);

    ttq_ram #(
        .WIDTH (EW),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        status.req_run     = (req_reg.req_type == REQ_RUN);
        status.full        = (count_reg == DEPTH_C);
        status.idx_zero    = (idx_reg == '0);
        status.entry_later = (rd_key > new_key);
        status.due_stop    = (due_reg == count_reg) || (32'(due_reg) >= RUN_LIMIT);
        status.due_zero    = (due_reg == '0);
        status.out_free    = !rsp_valid_reg || !rsp_stall;
    end

    always_comb
    begin
        if (cmd.emit_kind == KIND_ADD_OK)
        begin
            occ_calc = count_reg + CW'(1);
        end
        else
        begin
            occ_calc = count_reg - due_reg;
        end
        rsp_new.result_kind = cmd.emit_kind;
        rsp_new.due_tag     = (cmd.emit_kind == KIND_TASK_DUE) ? pend_tag_reg : 16'd0;
        rsp_new.last_result = cmd.emit_last;
        rsp_new.occupancy   = OCC_W'(occ_calc);
    end

    always_comb
    begin
        count_next = count_reg;
        head_next  = head_reg;
        idx_next   = idx_reg;
        due_next   = due_reg;
        if (cmd.commit_add)
        begin
            count_next = count_reg + CW'(1);
        end
        if (cmd.commit_run)
        begin
            // drop the delivered tasks from the front
            count_next = count_reg - due_reg;
            head_next  = phys_addr(head_reg, due_reg);
        end
        if (cmd.idx_init)
        begin
            idx_next = count_reg;
        end
        else if (cmd.wr_shift)
        begin
            idx_next = idx_reg - CW'(1);
        end
        if (cmd.load_req || cmd.commit_run)
        begin
            due_next = '0;
        end
        else if (cmd.due_inc)
        begin
            due_next = due_reg + CW'(1);
        end
        if (cmd.emit)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            head_reg      <= '0;
            idx_reg       <= '0;
            due_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            head_reg      <= head_next;
            idx_reg       <= idx_next;
            due_reg       <= due_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_reg <= req_data;
        end
        if (cmd.due_inc)
        begin
            pend_tag_reg <= rd_entry.tag;
        end
        if (cmd.emit)
        begin
            rsp_reg <= rsp_new;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("task count beyond queue depth");

    a_due_bound: assert property (@(posedge clk) disable iff (!rst_n)
        due_reg <= count_reg)
        else $error("more tasks due than held");

    a_add_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit_add |-> count_reg < DEPTH_C)
        else $error("task added to a full queue");

    a_shift_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_shift |-> idx_reg != '0)
        else $error("shift below the front of the queue");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!rsp_valid_reg || !rsp_stall))
        else $error("result overwritten while stalled");

endmodule

// ----- rtl/core/ttq_ctrl.sv -----
module ttq_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  ttq_pkg::ttq_status_t status,
    output ttq_pkg::ttq_cmd_t    cmd
);

    import ttq_pkg::*;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DECIDE   = 4'd1;
    localparam logic [3:0] S_ADD_STEP = 4'd2;
    localparam logic [3:0] S_ADD_CMP  = 4'd3;
    localparam logic [3:0] S_ADD_DONE = 4'd4;
    localparam logic [3:0] S_ADD_REJ  = 4'd5;
    localparam logic [3:0] S_RUN_STEP = 4'd6;
    localparam logic [3:0] S_RUN_CMP  = 4'd7;
    localparam logic [3:0] S_RUN_DONE = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign req_stall = (state_reg != S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (status.req_run)
                begin
                    state_next = S_RUN_STEP;
                end
                else if (status.full)
                begin
                    state_next = S_ADD_REJ;
                end
                else
                begin
                    cmd.idx_init = 1'b1;
                    state_next   = S_ADD_STEP;
                end
            end
            S_ADD_STEP:
            begin
                if (status.idx_zero)
                begin
                    cmd.wr_new = 1'b1;
                    state_next = S_ADD_DONE;
                end
                else
                begin
                    cmd.rd_add = 1'b1;
                    state_next = S_ADD_CMP;
                end
            end
            S_ADD_CMP:
            begin
                // move later tasks up one slot; equal times stay in front
                if (status.entry_later)
                begin
                    cmd.wr_shift = 1'b1;
                    state_next   = S_ADD_STEP;
                end
                else
                begin
                    cmd.wr_new = 1'b1;
                    state_next = S_ADD_DONE;
                end
            end
            S_ADD_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.emit       = 1'b1;
                    cmd.emit_kind  = KIND_ADD_OK;
                    cmd.emit_last  = 1'b1;
                    cmd.commit_add = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_ADD_REJ:
            begin
                if (status.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = KIND_ADD_FULL;
                    cmd.emit_last = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_RUN_STEP:
            begin
                if (status.due_stop)
                begin
                    state_next = S_RUN_DONE;
                end
                else
                begin
                    cmd.rd_run = 1'b1;
                    state_next = S_RUN_CMP;
                end
            end
            S_RUN_CMP:
            begin
                // hold one due task back until we know whether it is the last
                if (status.entry_later)
                begin
                    state_next = S_RUN_DONE;
                end
                else if (status.due_zero)
                begin
                    cmd.due_inc = 1'b1;
                    state_next  = S_RUN_STEP;
                end
                else if (status.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = KIND_TASK_DUE;
                    cmd.due_inc   = 1'b1;
                    state_next    = S_RUN_STEP;
                end
            end
            S_RUN_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.emit       = 1'b1;
                    cmd.emit_kind  = status.due_zero ? KIND_NONE_DUE : KIND_TASK_DUE;
                    cmd.emit_last  = 1'b1;
                    cmd.commit_run = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- rtl/core/timed_task_queue.sv -----
// Sorted timer queue: holds up to QUEUE_DEPTH task tags ordered by due time
// (seconds, then nanoseconds; equal times keep arrival order).
// Request channel req_valid/req_stall/req_data: an add inserts task_tag at
// time_sec/time_nsec, a run carries the current time and drains every task
// due at or before it, at most sixteen per run.
// Result channel rsp_valid/rsp_stall/rsp_data: an add gives one result
// (accepted or rejected when full); a run gives one result per due task in
// time order, the final one flagged by last_result, or a single "nothing due".
// One request is worked at a time; req_stall is high until its last result
// sits in the output register. The entries live in a single-port-read RAM
// with registered read, so each queue entry visited takes a read state and
// a compare state: an add walks past the k tasks later than the new one, a
// run over the d tasks due.
// A stall on the result side holds the output register and pauses a run's walk.
// Reset empties the queue at once; no clearing pass is needed.
module timed_task_queue #(
    parameter int QUEUE_DEPTH = ttq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  ttq_pkg::ttq_req_t req_data,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output ttq_pkg::ttq_rsp_t rsp_data
);

    import ttq_pkg::*;

    ttq_cmd_t    cmd;
    ttq_status_t status;

    ttq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .status    (status),
        .cmd       (cmd)
    );

    ttq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_data  (req_data),
        .cmd       (cmd),
        .status    (status),
        .rsp_stall (rsp_stall),
        .rsp_valid (rsp_valid),
        .rsp_data  (rsp_data)
    );

endmodule
